FILE: src/obo_pkg.sv
// ----------------------------------------------------------------------------
// obo_pkg
// Shared constants and types for the straight-alpha over blend pipeline.
// ----------------------------------------------------------------------------
package obo_pkg;

   localparam int CHANNEL_BITS_DEF = 8;

   localparam int COLOR_LANES = 3;
   localparam int LANES       = 4;

   localparam int RED_LANE   = 0;
   localparam int GREEN_LANE = 1;
   localparam int BLUE_LANE  = 2;
   localparam int ALPHA_LANE = 3;

   // sideband that travels with each pixel through the divider stages
   typedef struct packed {
      logic valid;
      logic zero;
   } obo_tag_type;

endpackage

FILE: src/obo_req_if.sv
// ----------------------------------------------------------------------------
// obo_req_if
// Request channel: one foreground and one background pixel per transfer.
// ----------------------------------------------------------------------------
interface obo_req_if
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] fg_red;
   logic [CHANNEL_BITS-1:0] fg_green;
   logic [CHANNEL_BITS-1:0] fg_blue;
   logic [CHANNEL_BITS-1:0] fg_alpha;
   logic [CHANNEL_BITS-1:0] bg_red;
   logic [CHANNEL_BITS-1:0] bg_green;
   logic [CHANNEL_BITS-1:0] bg_blue;
   logic [CHANNEL_BITS-1:0] bg_alpha;

   modport source (
      output valid, fg_red, fg_green, fg_blue, fg_alpha,
             bg_red, bg_green, bg_blue, bg_alpha,
      input  ready
   );

   modport sink (
      input  valid, fg_red, fg_green, fg_blue, fg_alpha,
             bg_red, bg_green, bg_blue, bg_alpha,
      output ready
   );
endinterface

FILE: src/obo_rsp_if.sv
// ----------------------------------------------------------------------------
// obo_rsp_if
// Response channel: one composited pixel per transfer.
// ----------------------------------------------------------------------------
interface obo_rsp_if
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;
   logic [CHANNEL_BITS-1:0] out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

FILE: src/obo_mul_stage.sv
// ----------------------------------------------------------------------------
// obo_mul_stage
// First pipeline stage: channel-by-alpha products and the coverage terms.
// ----------------------------------------------------------------------------
module obo_mul_stage
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic                                          in_valid,
   input  logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0]      fg_color,
   input  logic [CHANNEL_BITS-1:0]                       fg_alpha,
   input  logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0]      bg_color,
   input  logic [CHANNEL_BITS-1:0]                       bg_alpha,
   output logic                                          valid_ff,
   output logic [COLOR_LANES-1:0][2*CHANNEL_BITS-1:0]    fg_prod_ff,
   output logic [COLOR_LANES-1:0][2*CHANNEL_BITS-1:0]    bg_prod_ff,
   output logic [2*CHANNEL_BITS-1:0]                     fg_cover_ff,
   output logic [2*CHANNEL_BITS-1:0]                     bg_cover_ff,
   output logic [CHANNEL_BITS-1:0]                       inv_ff
);

   localparam int PROD_BITS = 2 * CHANNEL_BITS;
   localparam logic [CHANNEL_BITS-1:0] MAX_CODE = {CHANNEL_BITS{1'b1}};

   logic [COLOR_LANES-1:0][PROD_BITS-1:0] fg_prod_in;
   logic [COLOR_LANES-1:0][PROD_BITS-1:0] bg_prod_in;
   logic [PROD_BITS-1:0]                  fg_cover_in;
   logic [PROD_BITS-1:0]                  bg_cover_in;
   logic [CHANNEL_BITS-1:0]               inv_in;

   always_comb begin
      inv_in = MAX_CODE - fg_alpha;
      // fa * max as shift and subtract
      fg_cover_in = {fg_alpha, {CHANNEL_BITS{1'b0}}} - PROD_BITS'(fg_alpha);
      bg_cover_in = PROD_BITS'(bg_alpha) * PROD_BITS'(inv_in);
      for (int c = 0; c < COLOR_LANES; c++) begin
         fg_prod_in[c] = PROD_BITS'(fg_color[c]) * PROD_BITS'(fg_alpha);
         bg_prod_in[c] = PROD_BITS'(bg_color[c]) * PROD_BITS'(bg_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fg_prod_ff  <= fg_prod_in;
         bg_prod_ff  <= bg_prod_in;
         fg_cover_ff <= fg_cover_in;
         bg_cover_ff <= bg_cover_in;
         inv_ff      <= inv_in;
      end
   end

endmodule

FILE: src/obo_mad_stage.sv
// ----------------------------------------------------------------------------
// obo_mad_stage
// Second pipeline stage: blended numerators, coverage, rounded dividend and
// divisor for every color lane, and the rounded output alpha.
// ----------------------------------------------------------------------------
module obo_mad_stage
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic                                          in_valid,
   input  logic [COLOR_LANES-1:0][2*CHANNEL_BITS-1:0]    fg_prod,
   input  logic [COLOR_LANES-1:0][2*CHANNEL_BITS-1:0]    bg_prod,
   input  logic [2*CHANNEL_BITS-1:0]                     fg_cover,
   input  logic [2*CHANNEL_BITS-1:0]                     bg_cover,
   input  logic [CHANNEL_BITS-1:0]                       inv,
   output obo_tag_type                                   tag_ff,
   output logic [COLOR_LANES-1:0][3*CHANNEL_BITS+1:0]    rem_ff,
   output logic [COLOR_LANES-1:0][2*CHANNEL_BITS:0]      div_ff,
   output logic [CHANNEL_BITS-1:0]                       alpha_ff
);

   localparam int NUM_BITS  = 3 * CHANNEL_BITS;
   localparam int WIDE_BITS = 3 * CHANNEL_BITS + 2;
   localparam int DIV_BITS  = 2 * CHANNEL_BITS + 1;
   localparam int COV_BITS  = 2 * CHANNEL_BITS;
   localparam logic [COV_BITS-1:0] HALF_DOWN = COV_BITS'((1 << (CHANNEL_BITS - 1)) - 1);

   logic [COV_BITS-1:0]                     cover_sum;
   logic [COLOR_LANES-1:0][NUM_BITS-1:0]    num;
   logic [COLOR_LANES-1:0][WIDE_BITS-1:0]   rem_in;
   logic [COLOR_LANES-1:0][DIV_BITS-1:0]    div_in;
   logic [COV_BITS-1:0]                     round_sum;
   logic [COV_BITS-1:0]                     alpha_sum;
   logic [CHANNEL_BITS-1:0]                 alpha_in;
   obo_tag_type                             tag_in;

   always_comb begin
      cover_sum = fg_cover + bg_cover;
      for (int c = 0; c < COLOR_LANES; c++) begin
         num[c] = ({fg_prod[c], {CHANNEL_BITS{1'b0}}} - NUM_BITS'(fg_prod[c]))
                + NUM_BITS'(bg_prod[c]) * NUM_BITS'(inv);
         // round half up: (2*num + cover) / (2*cover)
         rem_in[c] = WIDE_BITS'({num[c], 1'b0}) + WIDE_BITS'(cover_sum);
         div_in[c] = {cover_sum, 1'b0};
      end
      // alpha: round(cover / max), division by 2^n - 1 as add and shift
      round_sum = cover_sum + HALF_DOWN;
      alpha_sum = round_sum + COV_BITS'(1) + (round_sum >> CHANNEL_BITS);
      alpha_in  = alpha_sum[COV_BITS-1:CHANNEL_BITS];
      tag_in.valid = in_valid;
      tag_in.zero  = (cover_sum == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (load) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= rem_in;
         div_ff   <= div_in;
         alpha_ff <= alpha_in;
      end
   end

endmodule

FILE: src/obo_div_step.sv
// ----------------------------------------------------------------------------
// obo_div_step
// One restoring-division stage: settles one quotient bit in each of the three
// color lanes and carries the finished alpha along.
// ----------------------------------------------------------------------------
module obo_div_step
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int SHIFT        = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  obo_tag_type                                   in_tag,
   input  logic [COLOR_LANES-1:0][3*CHANNEL_BITS+1:0]    in_rem,
   input  logic [COLOR_LANES-1:0][2*CHANNEL_BITS:0]      in_div,
   input  logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0]      in_quo,
   input  logic [CHANNEL_BITS-1:0]                       in_alpha,
   output obo_tag_type                                   tag_ff,
   output logic [COLOR_LANES-1:0][3*CHANNEL_BITS+1:0]    rem_ff,
   output logic [COLOR_LANES-1:0][2*CHANNEL_BITS:0]      div_ff,
   output logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0]      quo_ff,
   output logic [CHANNEL_BITS-1:0]                       alpha_ff
);

   localparam int WIDE_BITS = 3 * CHANNEL_BITS + 2;

   logic [COLOR_LANES-1:0][WIDE_BITS-1:0]    trial;
   logic [COLOR_LANES-1:0]                   take;
   logic [COLOR_LANES-1:0][WIDE_BITS-1:0]    rem_in;
   logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0] quo_in;

   always_comb begin
      for (int l = 0; l < COLOR_LANES; l++) begin
         trial[l]         = WIDE_BITS'(in_div[l]) << SHIFT;
         take[l]          = (in_rem[l] >= trial[l]);
         rem_in[l]        = take[l] ? (in_rem[l] - trial[l]) : in_rem[l];
         quo_in[l]        = in_quo[l];
         quo_in[l][SHIFT] = take[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (load) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= rem_in;
         div_ff   <= in_div;
         quo_ff   <= quo_in;
         alpha_ff <= in_alpha;
      end
   end

endmodule

FILE: src/straight_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// straight_alpha_over_blend
// Porter-Duff over composite of a straight-alpha foreground pixel onto a
// straight-alpha background pixel. Accepts one pixel per clock unless a stalled
// response fills the pipeline, returns one pixel per transfer, and passes it
// through a product stage, a blend stage that also finishes the output alpha,
// then one restoring-division stage per quotient bit, shared in step by the
// three color lanes while the alpha rides along. Colors and alpha are rounded
// half up; a pixel whose two alphas are both zero comes out all zero. Every
// stage holds its pixel while the next one is full, so bubbles are squeezed
// out and a stalled response does not block new requests until the whole
// pipeline is full. No state survives a pixel.
// ----------------------------------------------------------------------------
module straight_alpha_over_blend
   import obo_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   obo_req_if.sink     req_bus,
   obo_rsp_if.source   rsp_bus
);

   localparam int WIDE_BITS = 3 * CHANNEL_BITS + 2;
   localparam int DIV_BITS  = 2 * CHANNEL_BITS + 1;
   localparam int PROD_BITS = 2 * CHANNEL_BITS;
   localparam int STAGES    = CHANNEL_BITS + 2;

   logic [STAGES-1:0] stage_valid;
   logic [STAGES-1:0] stage_load;

   logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0] fg_color;
   logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0] bg_color;

   logic                                  mul_valid;
   logic [COLOR_LANES-1:0][PROD_BITS-1:0] fg_prod;
   logic [COLOR_LANES-1:0][PROD_BITS-1:0] bg_prod;
   logic [PROD_BITS-1:0]                  fg_cover;
   logic [PROD_BITS-1:0]                  bg_cover;
   logic [CHANNEL_BITS-1:0]               inv;

   obo_tag_type                              tag_bus   [CHANNEL_BITS+1];
   logic [COLOR_LANES-1:0][WIDE_BITS-1:0]    rem_bus   [CHANNEL_BITS+1];
   logic [COLOR_LANES-1:0][DIV_BITS-1:0]     div_bus   [CHANNEL_BITS+1];
   logic [COLOR_LANES-1:0][CHANNEL_BITS-1:0] quo_bus   [CHANNEL_BITS+1];
   logic [CHANNEL_BITS-1:0]                  alpha_bus [CHANNEL_BITS+1];

   obo_tag_type                           last_tag;

   // per-stage load: a stage takes new data when empty or when it drains
   always_comb begin
      stage_valid[0] = mul_valid;
      for (int k = 0; k <= CHANNEL_BITS; k++) begin
         stage_valid[k+1] = tag_bus[k].valid;
      end
      stage_load[STAGES-1] = !stage_valid[STAGES-1] || rsp_bus.ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         stage_load[s] = !stage_valid[s] || stage_load[s+1];
      end
   end

   assign req_bus.ready = stage_load[0];

   always_comb begin
      fg_color[RED_LANE]   = req_bus.fg_red;
      fg_color[GREEN_LANE] = req_bus.fg_green;
      fg_color[BLUE_LANE]  = req_bus.fg_blue;
      bg_color[RED_LANE]   = req_bus.bg_red;
      bg_color[GREEN_LANE] = req_bus.bg_green;
      bg_color[BLUE_LANE]  = req_bus.bg_blue;
   end

   obo_mul_stage #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .load        (stage_load[0]),
      .in_valid    (req_bus.valid),
      .fg_color    (fg_color),
      .fg_alpha    (req_bus.fg_alpha),
      .bg_color    (bg_color),
      .bg_alpha    (req_bus.bg_alpha),
      .valid_ff    (mul_valid),
      .fg_prod_ff  (fg_prod),
      .bg_prod_ff  (bg_prod),
      .fg_cover_ff (fg_cover),
      .bg_cover_ff (bg_cover),
      .inv_ff      (inv)
   );

   obo_mad_stage #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mad (
      .clock    (clock),
      .reset    (reset),
      .load     (stage_load[1]),
      .in_valid (mul_valid),
      .fg_prod  (fg_prod),
      .bg_prod  (bg_prod),
      .fg_cover (fg_cover),
      .bg_cover (bg_cover),
      .inv      (inv),
      .tag_ff   (tag_bus[0]),
      .rem_ff   (rem_bus[0]),
      .div_ff   (div_bus[0]),
      .alpha_ff (alpha_bus[0])
   );

   assign quo_bus[0] = '0;

   // quotient bits msb first
   for (genvar k = 0; k < CHANNEL_BITS; k++) begin : g_div
      obo_div_step #(
         .CHANNEL_BITS (CHANNEL_BITS),
         .SHIFT        (CHANNEL_BITS - 1 - k)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .load     (stage_load[k+2]),
         .in_tag   (tag_bus[k]),
         .in_rem   (rem_bus[k]),
         .in_div   (div_bus[k]),
         .in_quo   (quo_bus[k]),
         .in_alpha (alpha_bus[k]),
         .tag_ff   (tag_bus[k+1]),
         .rem_ff   (rem_bus[k+1]),
         .div_ff   (div_bus[k+1]),
         .quo_ff   (quo_bus[k+1]),
         .alpha_ff (alpha_bus[k+1])
      );
   end

   assign last_tag = tag_bus[CHANNEL_BITS];

   always_comb begin
      rsp_bus.valid     = last_tag.valid;
      rsp_bus.out_red   = last_tag.zero ? '0 : quo_bus[CHANNEL_BITS][RED_LANE];
      rsp_bus.out_green = last_tag.zero ? '0 : quo_bus[CHANNEL_BITS][GREEN_LANE];
      rsp_bus.out_blue  = last_tag.zero ? '0 : quo_bus[CHANNEL_BITS][BLUE_LANE];
      rsp_bus.out_alpha = last_tag.zero ? '0 : alpha_bus[CHANNEL_BITS];
   end

   // any nonzero coverage is at least one full code of alpha
   a_alpha_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !last_tag.zero) |-> (rsp_bus.out_alpha != '0))
      else $error("nonzero coverage produced zero alpha");

   a_color_rem : assert property (@(posedge clock) disable iff (reset)
      (last_tag.valid && !last_tag.zero) |->
      (rem_bus[CHANNEL_BITS][RED_LANE] <
       WIDE_BITS'(div_bus[CHANNEL_BITS][RED_LANE])))
      else $error("color division remainder not below divisor");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&stage_valid) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while pipeline full and response stalled");

endmodule
